// ----- sv/plte_pkg.sv -----
// Package for the path length and time estimator: payload structs and
// fixed constants. Depends on nothing; taken in by the top level.
`default_nettype none

package plte_pkg;

    localparam int unsigned COORD_W = 24;
    localparam int unsigned DIFF_W  = COORD_W + 1;
    localparam int unsigned SQ_W    = 2 * DIFF_W;
    localparam int unsigned SEG_W   = 26;
    localparam int unsigned ROOT_W  = 25;
    localparam int unsigned TOT_W   = 48;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned RATE_W  = 17;
    localparam int unsigned MULC_W  = 16;
    localparam int unsigned DVD_W   = ROOT_W + MULC_W;

    localparam int unsigned SQ_STEPS   = DIFF_W;
    localparam int unsigned ROOT_STEPS = ROOT_W;
    localparam int unsigned DIV_STEPS  = DVD_W;

    localparam logic [RATE_W-1:0] RAPID_RATE    = 17'd5000;
    localparam logic [RATE_W-1:0] FEED_RESET    = 17'd1000;
    localparam logic [MULC_W-1:0] US_PER_MM_MIN = 16'd60000;

    typedef struct packed {
        logic                      start_path;
        logic signed [COORD_W-1:0] x_um;
        logic signed [COORD_W-1:0] y_um;
        logic signed [COORD_W-1:0] z_um;
        logic                      is_rapid;
    } t_point;

    typedef struct packed {
        logic [SEG_W-1:0] segment_length_um;
        logic [TOT_W-1:0] total_distance_um;
        logic [TOT_W-1:0] total_time_us;
        logic [CNT_W-1:0] move_count;
    } t_result;

endpackage

`default_nettype wire

// ----- sv/plte_stream_if.sv -----
// Valid/ready stream channel carrying one payload of type T.
// Stands alone; the payload type comes from plte_pkg at the instance.
`default_nettype none

interface plte_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/path_length_time_estimator.sv -----
// Top level of the toolpath length and machining time estimator.
// Depends on plte_pkg and on plte_stream_if for its two channels.
//
// Use: points arrive on i_point (valid/ready); one request on i_point gives
// exactly one request on o_result carrying the segment length and the
// running totals. feed_rate is written through the APB port at addresses 0 to 3.
// A point that starts a path, or the first point after reset, goes straight
// to the final state. Any other point passes through the three bit-serial
// squarers, the two sum states, the restoring square root, the constant
// product and the restoring divider, one point at a time. A zero-length
// segment skips the divider.
// A finished result waits in the output register; the block takes the next
// point while it waits and only holds its final state if that point is
// done before the receiver has taken the earlier result.
// Reset is synchronous and clears the previous point, the totals, the
// output valid flag and sets feed_rate to 1000 mm/min.
`default_nettype none

module path_length_time_estimator
    import plte_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    plte_stream_if.sink       i_point,
    plte_stream_if.source     o_result,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQR,
        S_SUM1,
        S_SUM2,
        S_SQRT,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [5:0]          r_cnt;
    logic [RATE_W-1:0]   r_feed_rate;

    logic [COORD_W-1:0]  r_prev_x, r_prev_y, r_prev_z;
    logic                r_have_prev;
    logic [TOT_W-1:0]    r_dist;
    logic [TOT_W-1:0]    r_time;
    logic [CNT_W-1:0]    r_moves;
    logic                r_rapid;

    logic [DIFF_W-1:0]   r_ax, r_ay, r_az;
    logic [DIFF_W-1:0]   r_bx, r_by, r_bz;
    logic [SQ_W-1:0]     r_px, r_py, r_pz;
    logic [SQ_W-1:0]     r_rad;
    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [ROOT_W-1:0]   r_seg;
    logic [DVD_W-1:0]    r_dvd;
    logic [RATE_W-1:0]   r_drem;
    logic [RATE_W-1:0]   r_divisor;

    logic                r_out_valid;
    t_result             r_out;

    logic                in_fire;
    logic                cfg_wr;
    logic [DIFF_W-1:0]   n_ax, n_ay, n_az;
    logic [DIFF_W:0]     n_sx, n_sy, n_sz;
    logic [ROOT_W+3:0]   n_cur, n_trial, n_diff;
    logic [RATE_W:0]     n_dcur, n_ddiff;
    logic [TOT_W:0]      n_dist_sum, n_time_sum;
    logic [TOT_W-1:0]    n_dist, n_time;
    logic [CNT_W-1:0]    n_moves;
    logic [RATE_W-1:0]   n_rate;

    function automatic logic [DIFF_W-1:0] abs_diff(input logic [COORD_W-1:0] a,
                                                   input logic [COORD_W-1:0] b);
        logic [DIFF_W-1:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[DIFF_W-1] ? (~d + 1'b1) : d;
    endfunction

    assign in_fire        = i_point.valid && i_point.ready;
    assign i_point.ready  = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-RATE_W){1'b0}}, r_feed_rate};

    always_comb begin
        n_ax = abs_diff(i_point.data.x_um, r_prev_x);
        n_ay = abs_diff(i_point.data.y_um, r_prev_y);
        n_az = abs_diff(i_point.data.z_um, r_prev_z);

        // LSB-first shift-add: only the upper half of each product is added.
        n_sx = {1'b0, r_px[SQ_W-1:DIFF_W]} + (r_bx[0] ? {1'b0, r_ax} : '0);
        n_sy = {1'b0, r_py[SQ_W-1:DIFF_W]} + (r_by[0] ? {1'b0, r_ay} : '0);
        n_sz = {1'b0, r_pz[SQ_W-1:DIFF_W]} + (r_bz[0] ? {1'b0, r_az} : '0);

        // Square root, two radicand bits per step.
        n_cur   = {r_rem, r_rad[SQ_W-1:SQ_W-2]};
        n_trial = {2'b00, r_root, 2'b01};
        n_diff  = n_cur - n_trial;

        // Restoring divider, one quotient bit per step.
        n_dcur  = {r_drem, r_dvd[DVD_W-1]};
        n_ddiff = n_dcur - {1'b0, r_divisor};

        n_rate = r_rapid ? RAPID_RATE
                         : ((r_feed_rate == '0) ? {{(RATE_W-1){1'b0}}, 1'b1} : r_feed_rate);

        n_dist_sum = {1'b0, r_dist} + {{(TOT_W+1-ROOT_W){1'b0}}, r_seg};
        n_time_sum = {1'b0, r_time} + {{(TOT_W+1-DVD_W){1'b0}}, r_dvd};
        n_dist     = n_dist_sum[TOT_W] ? '1 : n_dist_sum[TOT_W-1:0];
        n_time     = r_time;
        n_moves    = r_moves;
        if (r_seg != '0) begin
            n_time  = n_time_sum[TOT_W] ? '1 : n_time_sum[TOT_W-1:0];
            n_moves = (r_moves == '1) ? r_moves : r_moves + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_feed_rate <= FEED_RESET;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_prev_z    <= '0;
            r_have_prev <= 1'b0;
            r_dist      <= '0;
            r_time      <= '0;
            r_moves     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_feed_rate <= pwdata[RATE_W-1:0];
            end
            // In the final state a taken result is replaced by the new one below.
            if (o_result.valid && o_result.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_prev_x    <= i_point.data.x_um;
                        r_prev_y    <= i_point.data.y_um;
                        r_prev_z    <= i_point.data.z_um;
                        r_have_prev <= 1'b1;
                        r_rapid     <= i_point.data.is_rapid;
                        r_ax        <= n_ax;
                        r_ay        <= n_ay;
                        r_az        <= n_az;
                        r_bx        <= n_ax;
                        r_by        <= n_ay;
                        r_bz        <= n_az;
                        r_px        <= '0;
                        r_py        <= '0;
                        r_pz        <= '0;
                        r_seg       <= '0;
                        r_cnt       <= '0;
                        if (i_point.data.start_path) begin
                            r_dist  <= '0;
                            r_time  <= '0;
                            r_moves <= '0;
                            r_state <= S_FIN;
                        end else if (!r_have_prev) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_SQR;
                        end
                    end
                end
                S_SQR: begin
                    r_px  <= {n_sx, r_px[DIFF_W-1:1]};
                    r_py  <= {n_sy, r_py[DIFF_W-1:1]};
                    r_pz  <= {n_sz, r_pz[DIFF_W-1:1]};
                    r_bx  <= r_bx >> 1;
                    r_by  <= r_by >> 1;
                    r_bz  <= r_bz >> 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(SQ_STEPS - 1)) begin
                        r_state <= S_SUM1;
                    end
                end
                S_SUM1: begin
                    r_rad   <= r_px + r_py;
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    r_rad   <= r_rad + r_pz;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= '0;
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    r_rad <= {r_rad[SQ_W-3:0], 2'b00};
                    if (n_cur >= n_trial) begin
                        r_rem  <= n_diff[ROOT_W+1:0];
                        r_root <= {r_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= n_cur[ROOT_W+1:0];
                        r_root <= {r_root[ROOT_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(ROOT_STEPS - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_seg     <= r_root;
                    r_dvd     <= r_root * US_PER_MM_MIN;
                    r_divisor <= n_rate;
                    r_drem    <= '0;
                    r_cnt     <= '0;
                    // A zero-length segment adds no time, so the divide is skipped.
                    r_state   <= (r_root == '0) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    if (n_dcur >= {1'b0, r_divisor}) begin
                        r_drem <= n_ddiff[RATE_W-1:0];
                        r_dvd  <= {r_dvd[DVD_W-2:0], 1'b1};
                    end else begin
                        r_drem <= n_dcur[RATE_W-1:0];
                        r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 6'(DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_dist  <= n_dist;
                        r_time  <= n_time;
                        r_moves <= n_moves;
                        r_out.segment_length_um <= {{(SEG_W-ROOT_W){1'b0}}, r_seg};
                        r_out.total_distance_um <= n_dist;
                        r_out.total_time_us     <= n_time;
                        r_out.move_count        <= n_moves;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // The square root remainder never exceeds twice the partial root.
    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_rem <= {1'b0, r_root, 1'b0}))
        else $error("square root remainder out of range");

    // The divider's partial remainder stays below the divisor.
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_drem < r_divisor))
        else $error("divider remainder not below divisor");

    // A nonzero segment has always been counted as a move.
    a_move_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.data.segment_length_um == '0 ||
                            o_result.data.move_count != '0))
        else $error("nonzero segment without a counted move");

    // The running distance always includes the segment just reported.
    a_dist_covers_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.data.total_distance_um >=
                            {{(TOT_W-SEG_W){1'b0}}, o_result.data.segment_length_um}))
        else $error("total distance below segment length");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for path_length_time_estimator: drives toolpath points,
// writes feed_rate over APB and checks each result against a directed expectation or
// an in-bench estimate. Depends on plte_pkg and plte_stream_if from the RTL.
`timescale 1ns / 1ps

module tb_top
    import plte_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned SETTLE_CYCLES = 120;

    localparam logic [2:0] FEED_RATE_ADDR = 3'd0;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;

    localparam bit [RATE_W-1:0] FEED_AT_RESET    = 17'd1000;
    localparam bit [63:0]       RAPID_MM_PER_MIN = 64'd5000;
    localparam bit [63:0]       US_PER_MIN       = 64'd60000;
    localparam bit [63:0]       TOTAL_MAX        = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        t_point  pt;
        bit      typed;
        t_result want;
    } t_row;

    typedef struct {
        logic [31:0] feed_word;
        int          send_idle;
        int          recv_stall;
        int          n_points;
        bit          sweep;
    } t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    plte_stream_if #(.T(t_point))  point_ch ();
    plte_stream_if #(.T(t_result)) result_ch ();

    path_length_time_estimator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_point  (point_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Estimator state as the block should hold it.
    logic signed [COORD_W-1:0] last_x, last_y, last_z;
    bit                        holds_point;
    bit [TOT_W-1:0]            dist_total;
    bit [TOT_W-1:0]            time_total;
    bit [CNT_W-1:0]            move_total;
    bit [RATE_W-1:0]           feed_cfg;

    t_result     expected_totals[$];
    t_row        dir_rows[$];
    t_phase      phases[8];
    int          errors = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int unsigned cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic bit [63:0] floor_sqrt(bit [63:0] v);
        bit [63:0] root;
        bit [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic bit [TOT_W-1:0] sat_total(bit [TOT_W-1:0] acc, bit [63:0] inc);
        bit [63:0] s;
        s = 64'(acc) + inc;
        return (s > TOTAL_MAX) ? TOTAL_MAX[TOT_W-1:0] : s[TOT_W-1:0];
    endfunction

    // Updates the running totals for one accepted point and returns the result it gives.
    function automatic t_result advance_estimate(t_point p);
        longint    dx, dy, dz;
        bit [63:0] root, rate, step_us;
        bit [SEG_W-1:0] seg;
        t_result   r;
        seg = '0;
        if (p.start_path) begin
            dist_total = '0;
            time_total = '0;
            move_total = '0;
        end else if (holds_point) begin
            dx = longint'(p.x_um) - longint'(last_x);
            dy = longint'(p.y_um) - longint'(last_y);
            dz = longint'(p.z_um) - longint'(last_z);
            root = floor_sqrt(64'(dx * dx + dy * dy + dz * dz));
            seg = root[SEG_W-1:0];
            dist_total = sat_total(dist_total, 64'(seg));
            if (seg != 0) begin
                if (p.is_rapid) begin
                    rate = RAPID_MM_PER_MIN;
                end else begin
                    rate = (feed_cfg == 0) ? 64'd1 : 64'(feed_cfg);
                end
                step_us = (64'(seg) * US_PER_MIN) / rate;
                time_total = sat_total(time_total, step_us);
                if (move_total != '1) begin
                    move_total = move_total + 1;
                end
            end
        end
        last_x = p.x_um;
        last_y = p.y_um;
        last_z = p.z_um;
        holds_point = 1'b1;
        r.segment_length_um = seg;
        r.total_distance_um = dist_total;
        r.total_time_us     = time_total;
        r.move_count        = move_total;
        return r;
    endfunction

    function automatic t_row pt_row(bit st, int x, int y, int z, bit rap, bit typed,
                                    longint unsigned seg, longint unsigned dist_um,
                                    longint unsigned tim, longint unsigned moves);
        t_row r;
        r.pt.start_path = st;
        r.pt.x_um = 24'(x);
        r.pt.y_um = 24'(y);
        r.pt.z_um = 24'(z);
        r.pt.is_rapid = rap;
        r.typed = typed;
        r.want.segment_length_um = seg[SEG_W-1:0];
        r.want.total_distance_um = dist_um[TOT_W-1:0];
        r.want.total_time_us     = tim[TOT_W-1:0];
        r.want.move_count        = moves[CNT_W-1:0];
        return r;
    endfunction

    task automatic append_row(t_row r);
        dir_rows.insert(dir_rows.size(), r);
    endtask

    function automatic logic signed [COORD_W-1:0] pick_extreme();
        case ($urandom_range(3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return '1;
        endcase
    endfunction

    // Next random point. Many moves are small steps from the last point, as a real path
    // would give; the rest are jumps, repeats, extremes and fresh path starts.
    function automatic t_point make_point(bit sweep, bit first);
        t_point p;
        int     pick;
        p.start_path = 1'b0;
        p.is_rapid = ($urandom_range(3) == 0);
        p.x_um = last_x;
        p.y_um = last_y;
        p.z_um = last_z;
        if (sweep) begin
            // Corner to corner at the longest length, so that the time total saturates.
            p.start_path = first;
            p.is_rapid = ($urandom_range(7) == 0);
            if (first || last_x != COORD_MIN) begin
                p.x_um = COORD_MIN;
                p.y_um = COORD_MIN;
                p.z_um = COORD_MIN;
            end else begin
                p.x_um = COORD_MAX;
                p.y_um = COORD_MAX;
                p.z_um = COORD_MAX;
            end
            return p;
        end
        pick = $urandom_range(99);
        if (pick < 5) begin
            p.start_path = 1'b1;
            p.x_um = 24'($urandom);
            p.y_um = 24'($urandom);
            p.z_um = 24'($urandom);
        end else if (pick < 15) begin
            // Same point again: a zero-length segment.
        end else if (pick < 55) begin
            p.x_um = last_x + 24'(int'($urandom_range(2000)) - 1000);
            p.y_um = last_y + 24'(int'($urandom_range(2000)) - 1000);
            p.z_um = last_z + 24'(int'($urandom_range(200)) - 100);
        end else if (pick < 70) begin
            p.x_um = last_x + 24'(int'($urandom_range(400000)) - 200000);
            p.y_um = last_y + 24'(int'($urandom_range(400000)) - 200000);
        end else if (pick < 85) begin
            p.x_um = 24'($urandom);
            p.y_um = 24'($urandom);
            p.z_um = 24'($urandom);
        end else if (pick < 95) begin
            p.x_um = pick_extreme();
            p.y_um = pick_extreme();
            p.z_um = pick_extreme();
        end else begin
            case ($urandom_range(2))
                0: p.x_um = last_x + (($urandom_range(1) == 0) ? 24'sd1 : -24'sd1);
                1: p.y_um = last_y + (($urandom_range(1) == 0) ? 24'sd1 : -24'sd1);
                default: p.z_um = last_z + (($urandom_range(1) == 0) ? 24'sd1 : -24'sd1);
            endcase
        end
        return p;
    endfunction

    // Offers one point, with random idle cycles first, and records what it should give.
    task automatic send_point(t_point p, bit typed, t_result want);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            point_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        point_ch.valid <= 1'b1;
        point_ch.data  <= p;
        @(posedge i_clk);
        while (!point_ch.ready) begin
            @(posedge i_clk);
        end
        predicted = advance_estimate(p);
        expected_totals.insert(expected_totals.size(), typed ? want : predicted);
    endtask

    task automatic write_feed_rate(logic [31:0] word);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FEED_RATE_ADDR;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        feed_cfg = word[RATE_W-1:0];
        @(posedge i_clk);
        if (prdata !== {{(32-RATE_W){1'b0}}, word[RATE_W-1:0]}) begin
            $display("%0t: feed_rate expected %0d actual %0d", $time, word[RATE_W-1:0],
                     prdata);
            errors++;
        end
    endtask

    task automatic wait_idle();
        while (expected_totals.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(t_result got);
        t_result want;
        if (expected_totals.size() == 0) begin
            $display("%0t: result with no point pending, expected none actual seg %0d dist %0d",
                     $time, got.segment_length_um, got.total_distance_um);
            errors++;
            return;
        end
        want = expected_totals.pop_front();
        compare_field("segment_length_um", 64'(want.segment_length_um),
                      64'(got.segment_length_um));
        compare_field("total_distance_um", 64'(want.total_distance_um),
                      64'(got.total_distance_um));
        compare_field("total_time_us", 64'(want.total_time_us), 64'(got.total_time_us));
        compare_field("move_count", 64'(want.move_count), 64'(got.move_count));
    endtask

    always @(posedge i_clk) begin
        if (result_ch.valid && result_ch.ready) begin
            check_result(result_ch.data);
        end
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        i_rst_n        <= 1'b0;
        point_ch.valid <= 1'b0;
        point_ch.data  <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;

        last_x = '0;
        last_y = '0;
        last_z = '0;
        holds_point = 1'b0;
        dist_total = '0;
        time_total = '0;
        move_total = '0;
        feed_cfg = FEED_AT_RESET;

        // Directed points at the reset feed rate of 1000 mm/min.
        append_row(pt_row(0, 100, 200, 300, 0, 1, 0, 0, 0, 0));
        append_row(pt_row(0, 100, 200, 300, 1, 1, 0, 0, 0, 0));
        append_row(pt_row(0, 3100, 4200, 300, 0, 1, 5000, 5000, 300000, 1));
        append_row(pt_row(0, 3100, 4200, -11700, 1, 1, 12000, 17000, 444000, 2));
        append_row(pt_row(1, -1, -1, -1, 0, 1, 0, 0, 0, 0));
        append_row(pt_row(0, 0, -1, -1, 0, 1, 1, 1, 60, 1));
        append_row(pt_row(0, 0, 0, -1, 1, 1, 1, 2, 72, 2));
        append_row(pt_row(0, 0, 0, 0, 0, 1, 1, 3, 132, 3));
        append_row(pt_row(0, 1, 1, 0, 0, 1, 1, 4, 192, 4));
        append_row(pt_row(1, -8388608, -8388608, -8388608, 1, 1, 0, 0, 0, 0));
        append_row(pt_row(0, 8388607, 8388607, 8388607, 0, 0, 0, 0, 0, 0));
        append_row(pt_row(0, -8388608, 8388607, -8388608, 1, 0, 0, 0, 0, 0));
        append_row(pt_row(0, -8388608, 8388607, -8388608, 0, 0, 0, 0, 0, 0));
        append_row(pt_row(0, 0, 0, 8388607, 0, 0, 0, 0, 0, 0));
        append_row(pt_row(1, 8388607, -8388608, 8388607, 1, 1, 0, 0, 0, 0));
        append_row(pt_row(0, 8388607, -8388608, 8388607, 0, 1, 0, 0, 0, 0));
        append_row(pt_row(0, -8388608, 0, 0, 0, 0, 0, 0, 0, 0));
        append_row(pt_row(0, -8388608, 0, 1, 1, 0, 0, 0, 0, 0));
        append_row(pt_row(1, 123456, -654321, 777777, 0, 1, 0, 0, 0, 0));
        append_row(pt_row(0, 123457, -654321, 777777, 0, 1, 1, 1, 60, 1));

        // The upper bits of the feed word lie outside the register, so 32'hFFFE_0000
        // leaves a feed rate of zero, which the block treats as 1 mm/min.
        phases = '{
            '{32'd1,                         0,  0, 150, 1'b0},
            '{32'd100000,                   73,  0, 150, 1'b0},
            '{32'h0001_FFFF,                 0, 73, 150, 1'b0},
            '{32'hFFFE_0000,                13, 13, 250, 1'b1},
            '{32'd1000,                      0,  0, 150, 1'b0},
            '{32'($urandom_range(1, 100000)), 73,  0, 150, 1'b0},
            '{32'($urandom_range(1, 100000)),  0, 73, 150, 1'b0},
            '{32'($urandom_range(1, 100000)), 13, 13, 150, 1'b0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].want);
        end
        point_ch.valid <= 1'b0;

        foreach (phases[k]) begin
            wait_idle();
            write_feed_rate(phases[k].feed_word);
            send_idle_pct  = phases[k].send_idle;
            recv_stall_pct = phases[k].recv_stall;
            for (int n = 0; n < phases[k].n_points; n++) begin
                send_point(make_point(phases[k].sweep, n == 0), 1'b0, '0);
            end
            point_ch.valid <= 1'b0;
        end

        wait_idle();
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- path_length_time_estimator.f -----
sv/plte_pkg.sv
sv/plte_stream_if.sv
sv/path_length_time_estimator.sv
tb/tb_top.sv
